FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the touch tracker checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define TPT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("touch tracker assertion failed");

// next-cycle implication, disabled during reset
`define TPT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("touch tracker assertion failed");

`endif

FILE: sv/tpt_pkg.sv
// ----------------------------------------------------------------------------
// tpt_pkg
// Types, codes and default sizes for the touch press tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package tpt_pkg;

    localparam int TABLE_SLOTS_DEF  = 32;
    localparam int POINTER_BITS_DEF = 8;
    localparam int COORD_BITS_DEF   = 12;

    localparam int MODE_W    = 2;
    localparam int STATUS_W  = 2;
    localparam int RADIUS_W  = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int OUT_USER_W = 1 + STATUS_W;

    typedef logic [MODE_W-1:0]    mode_t;
    typedef logic [STATUS_W-1:0]  status_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam mode_t MODE_PRESS   = 2'd0;
    localparam mode_t MODE_RELEASE = 2'd1;
    localparam mode_t MODE_CANCEL  = 2'd2;

    localparam status_t STATUS_OK       = 2'd0;
    localparam status_t STATUS_FULL     = 2'd1;
    localparam status_t STATUS_NO_ENTRY = 2'd2;
    localparam status_t STATUS_RSVD     = 2'd3;

    localparam cfg_idx_t REG_ORIENTATION   = 2'd0;
    localparam cfg_idx_t REG_SCREEN_WIDTH  = 2'd1;
    localparam cfg_idx_t REG_SCREEN_HEIGHT = 2'd2;
    localparam cfg_idx_t REG_TAP_RADIUS_SQ = 2'd3;

    localparam logic [1:0] ORIENT_PORTRAIT_BOTTOM  = 2'd0;
    localparam logic [1:0] ORIENT_PORTRAIT_TOP     = 2'd1;
    localparam logic [1:0] ORIENT_LANDSCAPE_RIGHT  = 2'd2;
    localparam logic [1:0] ORIENT_LANDSCAPE_LEFT   = 2'd3;

    localparam logic [RADIUS_W-1:0] TAP_RADIUS_SQ_RST = 16'd25;

endpackage

`default_nettype wire

FILE: sv/touch_press_tracker_tap_detect.sv
// ----------------------------------------------------------------------------
// touch_press_tracker_tap_detect
// Pointer table tracker with orientation remap and tap detection.
// ----------------------------------------------------------------------------
//  channel   dir  tdata                           tuser
//  s_*       in   pointer, raw_x, raw_y           mode
//  m_*       out  pos_x, pos_y                    tap, status
//  cfg_*     in   write only: cfg_we, cfg_addr, cfg_data
//
//  Each event runs a sequential scan of the slot RAM, one entry per cycle, then
//  the table update; a release that finds its pointer also computes the squared
//  distance on one shared multiplier. s_tready is high only when no event is in
//  work, so an event is taken only once the previous one has reached the result
//  register. The result register holds until m_tready; the next event is taken
//  meanwhile and waits in its last state while the register is full. Reset
//  clears all slot valid bits at once.
// ----------------------------------------------------------------------------
`default_nettype none

module touch_press_tracker_tap_detect #(
    parameter int TABLE_SLOTS  = tpt_pkg::TABLE_SLOTS_DEF,
    parameter int POINTER_BITS = tpt_pkg::POINTER_BITS_DEF,
    parameter int COORD_BITS   = tpt_pkg::COORD_BITS_DEF,
    localparam int IN_DATA_W   = ((POINTER_BITS + 2 * COORD_BITS + 7) / 8) * 8,
    localparam int OUT_DATA_W  = ((2 * COORD_BITS + 7) / 8) * 8
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [IN_DATA_W-1:0]              s_tdata,   // pointer, raw_x, raw_y
    input  wire logic [tpt_pkg::MODE_W-1:0]        s_tuser,   // mode
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [OUT_DATA_W-1:0]                  m_tdata,   // pos_x, pos_y
    output logic [tpt_pkg::OUT_USER_W-1:0]         m_tuser,   // tap, status
    input  wire logic                              cfg_we,
    input  wire logic [tpt_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  wire logic [tpt_pkg::CFG_DATA_W-1:0]    cfg_data
);

    import tpt_pkg::*;

    localparam int IDX_W   = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CNT_W   = $clog2(TABLE_SLOTS + 1);
    localparam int ENTRY_W = POINTER_BITS + 2 * COORD_BITS;
    localparam int SQ_W    = 2 * COORD_BITS;
    localparam int SUM_W   = SQ_W + 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EXEC,
        ST_SQX,
        ST_SQY,
        ST_SUM,
        ST_FIN
    } state_t;

    state_t state_reg;

    // configuration
    logic [1:0]            orient_reg;
    logic [COORD_BITS-1:0] width_reg;
    logic [COORD_BITS-1:0] height_reg;
    logic [RADIUS_W-1:0]   radius_reg;

    // event
    mode_t                   mode_reg;
    logic [POINTER_BITS-1:0] ptr_reg;
    logic [COORD_BITS-1:0]   px_reg;
    logic [COORD_BITS-1:0]   py_reg;

    // scan
    logic [TABLE_SLOTS-1:0]  used_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic                    rd_pend_reg;
    logic [IDX_W-1:0]        rd_idx_reg;
    logic                    hit_reg;
    logic [IDX_W-1:0]        hit_idx_reg;
    logic [COORD_BITS-1:0]   hit_x_reg;
    logic [COORD_BITS-1:0]   hit_y_reg;
    logic                    free_reg;
    logic [IDX_W-1:0]        free_idx_reg;

    // distance
    logic [COORD_BITS-1:0]   dx_reg;
    logic [COORD_BITS-1:0]   dy_reg;
    logic [SQ_W-1:0]         prod_reg;
    logic [SQ_W-1:0]         acc_reg;
    logic                    tap_reg;
    status_t                 status_reg;

    // result
    logic                    out_valid_reg;
    logic [COORD_BITS-1:0]   out_x_reg;
    logic [COORD_BITS-1:0]   out_y_reg;
    logic                    out_tap_reg;
    status_t                 out_status_reg;

    // input field unpack
    logic [POINTER_BITS-1:0] in_ptr;
    logic [COORD_BITS-1:0]   in_x;
    logic [COORD_BITS-1:0]   in_y;
    mode_t                   in_mode;
    logic [COORD_BITS-1:0]   map_x;
    logic [COORD_BITS-1:0]   map_y;
    logic [COORD_BITS-1:0]   h_minus_y;
    logic [COORD_BITS-1:0]   w_minus_x;

    assign in_ptr  = s_tdata[POINTER_BITS-1:0];
    assign in_x    = s_tdata[POINTER_BITS +: COORD_BITS];
    assign in_y    = s_tdata[POINTER_BITS + COORD_BITS +: COORD_BITS];
    assign in_mode = s_tuser;

    assign h_minus_y = (height_reg > in_y) ? (height_reg - in_y) : '0;
    assign w_minus_x = (width_reg > in_x) ? (width_reg - in_x) : '0;

    always_comb
    begin
        map_x = in_x;
        map_y = in_y;
        case (orient_reg)
            ORIENT_PORTRAIT_BOTTOM:
            begin
                map_y = h_minus_y;
            end
            ORIENT_PORTRAIT_TOP:
            begin
                map_x = w_minus_x;
            end
            ORIENT_LANDSCAPE_RIGHT:
            begin
                map_x = in_y;
                map_y = in_x;
            end
            default:
            begin
                map_x = h_minus_y;
                map_y = w_minus_x;
            end
        endcase
    end

    // slot RAM: {press_y, press_x, pointer}
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;
    logic [IDX_W-1:0]   ram_raddr;

    logic s_fire;
    logic m_fire;
    logic out_load;
    logic scan_issue;
    logic scan_end;
    logic ptr_match;
    logic is_press;
    logic store_ok;

    assign s_tready   = (state_reg == ST_IDLE);
    assign s_fire     = s_tvalid && s_tready;
    assign m_fire     = out_valid_reg && m_tready;
    assign out_load   = (state_reg == ST_FIN) && (!out_valid_reg || m_tready);
    assign scan_issue = (state_reg == ST_SCAN) && (cnt_reg < CNT_W'(TABLE_SLOTS));
    assign scan_end   = (state_reg == ST_SCAN) && (cnt_reg == CNT_W'(TABLE_SLOTS));
    assign ram_raddr  = cnt_reg[IDX_W-1:0];
    assign ptr_match  = rd_pend_reg && used_reg[rd_idx_reg]
                        && (ram_rdata[POINTER_BITS-1:0] == ptr_reg);
    assign is_press   = (mode_reg == MODE_PRESS);
    assign store_ok   = hit_reg || free_reg;

    assign ram_we    = (state_reg == ST_EXEC) && is_press && store_ok;
    assign ram_waddr = hit_reg ? hit_idx_reg : free_idx_reg;
    assign ram_wdata = {py_reg, px_reg, ptr_reg};

    tpt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // shared squarer
    logic [COORD_BITS-1:0] mul_op;
    logic [SQ_W-1:0]       mul_out;
    logic [SUM_W-1:0]      dist_sum;

    assign mul_op   = (state_reg == ST_SQX) ? dx_reg : dy_reg;
    assign mul_out  = mul_op * mul_op;
    assign dist_sum = {1'b0, acc_reg} + {1'b0, prod_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            orient_reg <= '0;
            width_reg  <= '0;
            height_reg <= '0;
            radius_reg <= TAP_RADIUS_SQ_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_ORIENTATION:   orient_reg <= cfg_data[1:0];
                REG_SCREEN_WIDTH:  width_reg  <= cfg_data[COORD_BITS-1:0];
                REG_SCREEN_HEIGHT: height_reg <= cfg_data[COORD_BITS-1:0];
                REG_TAP_RADIUS_SQ: radius_reg <= cfg_data[RADIUS_W-1:0];
                default:           orient_reg <= orient_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            used_reg      <= '0;
            cnt_reg       <= '0;
            rd_pend_reg   <= 1'b0;
            hit_reg       <= 1'b0;
            free_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_fire)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (s_fire)
                    begin
                        mode_reg    <= in_mode;
                        ptr_reg     <= in_ptr;
                        cnt_reg     <= '0;
                        rd_pend_reg <= 1'b0;
                        hit_reg     <= 1'b0;
                        free_reg    <= 1'b0;
                        tap_reg     <= 1'b0;
                        status_reg  <= STATUS_OK;
                        if (in_mode == MODE_PRESS || in_mode == MODE_RELEASE)
                        begin
                            px_reg <= map_x;
                            py_reg <= map_y;
                        end
                        else
                        begin
                            px_reg <= '0;
                            py_reg <= '0;
                        end
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    rd_pend_reg <= scan_issue;
                    rd_idx_reg  <= cnt_reg[IDX_W-1:0];
                    if (scan_issue)
                    begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                        if (!free_reg && !used_reg[cnt_reg[IDX_W-1:0]])
                        begin
                            free_reg     <= 1'b1;
                            free_idx_reg <= cnt_reg[IDX_W-1:0];
                        end
                    end
                    if (ptr_match && !hit_reg)
                    begin
                        hit_reg     <= 1'b1;
                        hit_idx_reg <= rd_idx_reg;
                        hit_x_reg   <= ram_rdata[POINTER_BITS +: COORD_BITS];
                        hit_y_reg   <= ram_rdata[POINTER_BITS + COORD_BITS +: COORD_BITS];
                    end
                    if (scan_end)
                    begin
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC:
                begin
                    dx_reg <= (px_reg > hit_x_reg) ? (px_reg - hit_x_reg)
                                                   : (hit_x_reg - px_reg);
                    dy_reg <= (py_reg > hit_y_reg) ? (py_reg - hit_y_reg)
                                                   : (hit_y_reg - py_reg);
                    state_reg <= ((mode_reg == MODE_RELEASE) && hit_reg) ? ST_SQX : ST_FIN;
                    case (mode_reg)
                        MODE_PRESS:
                        begin
                            if (store_ok)
                            begin
                                used_reg[ram_waddr] <= 1'b1;
                            end
                            else
                            begin
                                status_reg <= STATUS_FULL;
                            end
                        end
                        MODE_RELEASE:
                        begin
                            if (hit_reg)
                            begin
                                used_reg[hit_idx_reg] <= 1'b0;
                            end
                            else
                            begin
                                status_reg <= STATUS_NO_ENTRY;
                            end
                        end
                        MODE_CANCEL:
                        begin
                            if (hit_reg)
                            begin
                                used_reg[hit_idx_reg] <= 1'b0;
                            end
                            else
                            begin
                                status_reg <= STATUS_NO_ENTRY;
                            end
                        end
                        default:
                        begin
                            status_reg <= STATUS_OK;
                        end
                    endcase
                end
                ST_SQX:
                begin
                    prod_reg  <= mul_out;
                    state_reg <= ST_SQY;
                end
                ST_SQY:
                begin
                    acc_reg   <= prod_reg;
                    prod_reg  <= mul_out;
                    state_reg <= ST_SUM;
                end
                ST_SUM:
                begin
                    tap_reg   <= (dist_sum < SUM_W'(radius_reg));
                    state_reg <= ST_FIN;
                end
                ST_FIN:
                begin
                    if (out_load)
                    begin
                        out_x_reg      <= px_reg;
                        out_y_reg      <= py_reg;
                        out_tap_reg    <= tap_reg;
                        out_status_reg <= status_reg;
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DATA_W'({out_y_reg, out_x_reg});
    assign m_tuser  = {out_status_reg, out_tap_reg};

endmodule

`default_nettype wire

FILE: sv/tpt_ram.sv
// ----------------------------------------------------------------------------
// tpt_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module tpt_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 32,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: sv/tpt_checker.sv
// ----------------------------------------------------------------------------
// tpt_checker
// Port-level checks for the touch press tracker, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module tpt_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [tpt_pkg::OUT_USER_W-1:0] m_tuser
);

    import tpt_pkg::*;

    logic    out_tap;
    status_t out_status;

    assign out_tap    = m_tuser[0];
    assign out_status = m_tuser[STATUS_W:1];

    // a pending result holds until it is taken
    `TPT_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tuser))

    // the event in work blocks the input side for the next cycle
    `TPT_ASSERT_NEXT(a_busy_after_transfer, clk, rst_n, s_tvalid && s_tready, !s_tready)

    // no reserved status code
    `TPT_ASSERT_NOW(a_status_code, clk, rst_n, m_tvalid, out_status != STATUS_RSVD)

    // a tap is only reported on a clean release
    `TPT_ASSERT_NOW(a_tap_ok, clk, rst_n, m_tvalid && out_tap, out_status == STATUS_OK)

endmodule

bind touch_press_tracker_tap_detect tpt_checker u_tpt_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tuser  (m_tuser)
);

`default_nettype wire
